/* rtl/adaptive_scalar_kalman_filter_defines.svh */
// Assertion macros shared by the checker.
`ifndef ADAPTIVE_SCALAR_KALMAN_FILTER_DEFINES_SVH
`define ADAPTIVE_SCALAR_KALMAN_FILTER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define ASKF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define ASKF_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/askf_pkg.sv */
`default_nettype none

package askf_pkg;

	localparam int EST_W   = 64;
	localparam int COV_W   = 33;
	localparam int NOISE_W = 32;
	localparam int PP_W    = 34;
	localparam int DEN_W   = 35;
	localparam int REM_W   = 35;
	localparam int UPPER_W = 63;
	localparam int LOWER_W = 64;
	localparam int HALF_W  = 32;
	localparam int PDATA_W = 64;
	localparam int PADDR_W = 6;

	localparam logic [DEN_W-1:0] MIN_DENOM = 35'd17;

	localparam logic [2:0] REG_MEAS_NOISE  = 3'd0;
	localparam logic [2:0] REG_QUIET_NOISE = 3'd1;
	localparam logic [2:0] REG_SPIKE_NOISE = 3'd2;
	localparam logic [2:0] REG_SPIKE_THR   = 3'd3;
	localparam logic [2:0] REG_UPPER_LIM   = 3'd4;
	localparam logic [2:0] REG_LOWER_LIM   = 3'd5;

	localparam logic [NOISE_W-1:0]        RST_MEAS_NOISE  = 32'd1677722;
	localparam logic [NOISE_W-1:0]        RST_QUIET_NOISE = 32'd16777;
	localparam logic [NOISE_W-1:0]        RST_SPIKE_NOISE = 32'd167772160;
	localparam logic [NOISE_W-1:0]        RST_SPIKE_THR   = 32'd8388608;
	localparam logic [UPPER_W-1:0]        RST_UPPER_LIM   = 63'd16777216000000000;
	localparam logic signed [LOWER_W-1:0] RST_LOWER_LIM   = -64'sd167772160000;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIFF,
		ST_MAG,
		ST_NOISE,
		ST_DEN,
		ST_DIV_INIT,
		ST_DIV,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_UPDATE,
		ST_COV,
		ST_WRITE
	} askf_state_t;

endpackage

`default_nettype wire

/* rtl/adaptive_scalar_kalman_filter.sv */
// Channel  Role       Handshake             Payload
// in       receiver   in_valid / in_stall   sample
// out      sender     out_valid / out_stall estimate, rejected, spike_mode
// cfg      APB slave  psel/penable/pready   paddr, pwrite, pwdata, prdata
//
// An updated item passes the restoring gain divider (one quotient bit per cycle) and the
// shared multiplier, which makes two passes for the step and one for the covariance; the
// covariance pass is skipped when the gain reaches one. A sample out of limits goes
// straight to the write state, and an update is skipped when the denominator is too small.
// in_stall is high while an item is in work; a result waits in the output register.
// arst_n restores the configuration, the state, a zero estimate and a covariance of one.
`default_nettype none

module adaptive_scalar_kalman_filter
	import askf_pkg::*;
#(
	parameter int FRAC_BITS  = 24,
	parameter int DATA_WIDTH = 64
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,

	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic signed [DATA_WIDTH-1:0] sample,

	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic signed [EST_W-1:0]           estimate,
	output logic                              rejected,
	output logic                              spike_mode,

	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [PADDR_W-1:0]           paddr,
	input  wire logic [PDATA_W-1:0]           pwdata,
	output logic [PDATA_W-1:0]                prdata,
	output logic                              pready
);

	localparam int QUO_W  = FRAC_BITS + 1;
	localparam int CNT_W  = $clog2(FRAC_BITS);
	localparam int PROD_W = QUO_W + PP_W;
	localparam int ACC_W  = EST_W + QUO_W;

	localparam logic [QUO_W-1:0]        ONE       = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [COV_W-1:0]        COV_RESET = COV_W'(ONE);
	localparam logic signed [EST_W:0]   D_MAX     = (65'sd1 <<< (DATA_WIDTH - 1)) - 65'sd1;
	localparam logic signed [EST_W:0]   D_MIN     = -D_MAX - 65'sd1;
	localparam logic [EST_W-1:0]        MAG_NEG   = D_MAX[EST_W-1:0] + 64'd1;

	// configuration
	logic [NOISE_W-1:0]        meas_q;
	logic [NOISE_W-1:0]        quiet_q;
	logic [NOISE_W-1:0]        spike_noise_q;
	logic [NOISE_W-1:0]        thr_q;
	logic [UPPER_W-1:0]        upper_q;
	logic signed [LOWER_W-1:0] lower_q;

	// control and filter state
	askf_state_t             state_q, state_d;
	logic                    out_valid_q;
	logic signed [EST_W-1:0] est_q;
	logic [COV_W-1:0]        cov_q;

	// working registers
	logic signed [DATA_WIDTH-1:0] sample_q;
	logic signed [EST_W:0]        diff_q;
	logic [EST_W-1:0]             mag_q;
	logic                         neg_q;
	logic                         spike_q;
	logic                         rej_q;
	logic [PP_W-1:0]              pp_q;
	logic [DEN_W-1:0]             den_q;
	logic [REM_W-1:0]             rem_q;
	logic [QUO_W-1:0]             quo_q;
	logic [CNT_W-1:0]             cnt_q;
	logic [ACC_W-1:0]             acc_q;
	logic signed [EST_W-1:0]      out_est_q;
	logic                         out_rej_q;
	logic                         out_spike_q;

	logic                    wr_en;
	logic [2:0]              reg_idx;
	logic                    in_xfer;
	logic                    out_free;
	logic signed [EST_W-1:0] s64;
	logic                    out_of_lim;
	logic                    spike_d;
	logic [PP_W-1:0]         pp_d;
	logic [DEN_W-1:0]        den_d;
	logic [REM_W:0]          rem_sh;
	logic [EST_W-1:0]        mag_d;
	logic [EST_W-1:0]        step;
	logic [QUO_W-1:0]        mul_a;
	logic [PP_W-1:0]         mul_b;
	logic [PROD_W-1:0]       mul_p;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[5:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meas_q        <= RST_MEAS_NOISE;
			quiet_q       <= RST_QUIET_NOISE;
			spike_noise_q <= RST_SPIKE_NOISE;
			thr_q         <= RST_SPIKE_THR;
			upper_q       <= RST_UPPER_LIM;
			lower_q       <= RST_LOWER_LIM;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_MEAS_NOISE:  meas_q        <= pwdata[NOISE_W-1:0];
				REG_QUIET_NOISE: quiet_q       <= pwdata[NOISE_W-1:0];
				REG_SPIKE_NOISE: spike_noise_q <= pwdata[NOISE_W-1:0];
				REG_SPIKE_THR:   thr_q         <= pwdata[NOISE_W-1:0];
				REG_UPPER_LIM:   upper_q       <= pwdata[UPPER_W-1:0];
				REG_LOWER_LIM:   lower_q       <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_MEAS_NOISE:  prdata = PDATA_W'(meas_q);
			REG_QUIET_NOISE: prdata = PDATA_W'(quiet_q);
			REG_SPIKE_NOISE: prdata = PDATA_W'(spike_noise_q);
			REG_SPIKE_THR:   prdata = PDATA_W'(thr_q);
			REG_UPPER_LIM:   prdata = PDATA_W'(upper_q);
			REG_LOWER_LIM:   prdata = lower_q;
			default:         prdata = '0;
		endcase
	end

	assign in_xfer  = in_valid & ~in_stall;
	assign out_free = ~out_valid_q | ~out_stall;

	assign s64        = EST_W'(sample_q);
	assign out_of_lim = (~s64[EST_W-1] && (s64[UPPER_W-1:0] > upper_q)) || (s64 < lower_q);

	always_comb begin
		if (!diff_q[EST_W]) begin
			mag_d = (diff_q > D_MAX) ? D_MAX[EST_W-1:0] : diff_q[EST_W-1:0];
		end else begin
			mag_d = (diff_q < D_MIN) ? MAG_NEG : EST_W'(-diff_q);
		end
	end

	assign spike_d = mag_q > EST_W'(thr_q);
	assign pp_d    = PP_W'(cov_q) + PP_W'(spike_d ? spike_noise_q : quiet_q);
	assign den_d   = DEN_W'(pp_q) + DEN_W'(meas_q);
	assign rem_sh  = {rem_q, 1'b0};
	assign step    = acc_q[FRAC_BITS +: EST_W];

	// shared multiplier: gain times magnitude halves, then (1 - gain) times Pp
	always_comb begin
		mul_a = quo_q;
		mul_b = PP_W'(mag_q[HALF_W-1:0]);
		case (state_q)
			ST_MUL_HI: mul_b = PP_W'(mag_q[EST_W-1:HALF_W]);
			ST_COV: begin
				mul_a = ONE - quo_q;
				mul_b = pp_q;
			end
			default: ;
		endcase
	end

	assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) state_d = ST_CHECK;
			end
			ST_CHECK:    state_d = out_of_lim ? ST_WRITE : ST_DIFF;
			ST_DIFF:     state_d = ST_MAG;
			ST_MAG:      state_d = ST_NOISE;
			ST_NOISE:    state_d = ST_DEN;
			ST_DEN:      state_d = (den_d < MIN_DENOM) ? ST_WRITE : ST_DIV_INIT;
			ST_DIV_INIT: state_d = ST_DIV;
			ST_DIV: begin
				if (cnt_q == CNT_W'(FRAC_BITS - 1)) state_d = ST_MUL_LO;
			end
			ST_MUL_LO:   state_d = ST_MUL_HI;
			ST_MUL_HI:   state_d = ST_UPDATE;
			ST_UPDATE:   state_d = (quo_q >= ONE) ? ST_WRITE : ST_COV;
			ST_COV:      state_d = ST_WRITE;
			ST_WRITE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default:     state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			est_q       <= '0;
			cov_q       <= COV_RESET;
		end else begin
			if (state_q == ST_WRITE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_CHECK && !out_of_lim && est_q == '0) begin
				est_q <= s64;
			end
			if (state_q == ST_UPDATE) begin
				est_q <= neg_q ? (est_q - step) : (est_q + step);
				if (quo_q >= ONE) cov_q <= '0;
			end
			if (state_q == ST_COV) begin
				cov_q <= mul_p[FRAC_BITS +: COV_W];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) sample_q <= sample;
		case (state_q)
			ST_CHECK: begin
				rej_q   <= out_of_lim;
				spike_q <= 1'b0;
			end
			ST_DIFF: diff_q <= {s64[EST_W-1], s64} - {est_q[EST_W-1], est_q};
			ST_MAG: begin
				mag_q <= mag_d;
				neg_q <= diff_q[EST_W];
			end
			ST_NOISE: begin
				spike_q <= spike_d;
				pp_q    <= pp_d;
			end
			ST_DEN: begin
				den_q <= den_d;
				rej_q <= den_d < MIN_DENOM;
			end
			ST_DIV_INIT: begin
				cnt_q <= '0;
				if (DEN_W'(pp_q) >= den_q) begin
					rem_q <= REM_W'(DEN_W'(pp_q) - den_q);
					quo_q <= QUO_W'(1);
				end else begin
					rem_q <= REM_W'(pp_q);
					quo_q <= '0;
				end
			end
			ST_DIV: begin
				cnt_q <= CNT_W'(cnt_q + 1'b1);
				if (rem_sh >= {1'b0, den_q}) begin
					rem_q <= REM_W'(rem_sh - {1'b0, den_q});
					quo_q <= {quo_q[QUO_W-2:0], 1'b1};
				end else begin
					rem_q <= REM_W'(rem_sh);
					quo_q <= {quo_q[QUO_W-2:0], 1'b0};
				end
			end
			ST_MUL_LO: acc_q <= ACC_W'(mul_p);
			ST_MUL_HI: acc_q <= acc_q + (ACC_W'(mul_p) << HALF_W);
			ST_WRITE: begin
				if (out_free) begin
					out_est_q   <= est_q;
					out_rej_q   <= rej_q;
					out_spike_q <= spike_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid  = out_valid_q;
	assign estimate   = out_est_q;
	assign rejected   = out_rej_q;
	assign spike_mode = out_spike_q;

endmodule

`default_nettype wire

/* rtl/askf_checker.sv */
`default_nettype none
`include "adaptive_scalar_kalman_filter_defines.svh"

module askf_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [63:0] estimate,
	input wire logic        rejected,
	input wire logic        spike_mode
);

	logic [1:0] pend_q;
	logic       in_xfer;
	logic       out_xfer;

	assign in_xfer  = in_valid & ~in_stall;
	assign out_xfer = out_valid & ~out_stall;

	// count items transferred in and not yet transferred out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 2'd0;
		end else if (in_xfer && !out_xfer) begin
			pend_q <= pend_q + 2'd1;
		end else if (out_xfer && !in_xfer) begin
			pend_q <= pend_q - 2'd1;
		end
	end

	`ASKF_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(estimate) && $stable(rejected) && $stable(spike_mode), "stalled result changed")
	`ASKF_ASSERT_NXT(a_busy_after_in, in_xfer, in_stall, "input not stalled after transfer")
	`ASKF_ASSERT_NXT(a_no_early_out, in_xfer, !$rose(out_valid), "result one cycle after input")
	`ASKF_ASSERT_IMP(a_out_has_item, out_valid, pend_q != 2'd0, "result without input item")
	`ASKF_ASSERT_IMP(a_pend_bound, 1'b1, pend_q != 2'd3, "more than two items in flight")

endmodule

bind adaptive_scalar_kalman_filter askf_checker u_askf_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.estimate   (estimate),
	.rejected   (rejected),
	.spike_mode (spike_mode)
);

`default_nettype wire
